[rtl/lssd_pkg.sv]
// Shared types, constants and codes for the line sensor steering decider.
package lssd_pkg;

  localparam int NUM_SENSORS = 8;
  localparam int SAMPLE_BITS = 12;
  localparam int CENTROID_SCALE = 10;

  localparam int DIST_W = 16;
  localparam int BAND_W = 7;
  localparam int CENT_W = 7;
  localparam int ERR_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // sum of all samples and sum of sample * (index + 1)
  localparam int SUM_W = SAMPLE_BITS + $clog2(NUM_SENSORS);
  localparam int WSUM_W = SAMPLE_BITS + $clog2(NUM_SENSORS * (NUM_SENSORS + 1) / 2);
  localparam int NUM_W = WSUM_W + $clog2(CENTROID_SCALE);
  localparam int DSH_W = SUM_W + CENT_W - 1;
  localparam int DIV_W = (NUM_W > DSH_W) ? NUM_W : DSH_W;
  localparam int CNT_MAX = (NUM_SENSORS > CENT_W) ? NUM_SENSORS : CENT_W;
  localparam int CNT_W = $clog2(CNT_MAX);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [WSUM_W-1:0] wsum_t;
  typedef logic [DIV_W-1:0] div_word_t;
  typedef logic [CENT_W-1:0] cent_t;
  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic signed [ERR_W:0] err_wide_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [BAND_W-1:0] band_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [1:0] {
    CMD_STOP    = 2'd0,
    CMD_FORWARD = 2'd1,
    CMD_LEFT    = 2'd2,
    CMD_RIGHT   = 2'd3
  } drive_cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OBSTACLE_LIMIT   = 3'd0,
    CFG_DARK_THRESHOLD   = 3'd1,
    CFG_BRIGHT_THRESHOLD = 3'd2,
    CFG_DEAD_BAND        = 3'd3,
    CFG_TURN_LIMIT       = 3'd4
  } cfg_reg_t;

  localparam int OP_CALIBRATE = 0;
  localparam int OP_RUN = 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_SCALE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic acc;
    logic scale;
    logic div_step;
    logic out_load;
  } lssd_cmd_t;

endpackage

[rtl/lssd_ctrl.sv]
// Sequencer for the decider: accumulate, scale, divide, decide.
module lssd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  logic               sum_zero,
  output lssd_pkg::lssd_cmd_t cmd
);

  lssd_pkg::state_t state_r, state_nxt;
  lssd_pkg::cnt_t   cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lssd_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and step counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      lssd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = lssd_pkg::ST_ACCUM;
          cnt_nxt   = lssd_pkg::cnt_t'(lssd_pkg::NUM_SENSORS - 1);
        end
      end
      lssd_pkg::ST_ACCUM: begin
        if (cnt_r == '0) begin
          state_nxt = lssd_pkg::ST_SCALE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      lssd_pkg::ST_SCALE: begin
        // all-zero frame skips the divide
        if (sum_zero) begin
          state_nxt = lssd_pkg::ST_DONE;
        end else begin
          state_nxt = lssd_pkg::ST_DIV;
          cnt_nxt   = lssd_pkg::cnt_t'(lssd_pkg::CENT_W - 1);
        end
      end
      lssd_pkg::ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = lssd_pkg::ST_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      lssd_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = lssd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lssd_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    case (state_r)
      lssd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      lssd_pkg::ST_ACCUM: begin
        cmd.acc = 1'b1;
      end
      lssd_pkg::ST_SCALE: begin
        cmd.scale = 1'b1;
      end
      lssd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      lssd_pkg::ST_DONE: begin
        cmd.out_load = !out_valid_r || out_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/lssd_dp.sv]
// Datapath: sample shift line, sum accumulators, restoring divider, decision, result register.
module lssd_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lssd_pkg::lssd_cmd_t      cmd,
  output logic                     sum_zero,
  input  logic                     in_operation,
  input  lssd_pkg::sample_t        in_samples [lssd_pkg::NUM_SENSORS],
  input  lssd_pkg::dist_t          in_distance_cm,
  input  logic                     cfg_we,
  input  lssd_pkg::cfg_idx_t       cfg_index,
  input  lssd_pkg::cfg_data_t      cfg_data,
  output lssd_pkg::cent_t          out_centroid,
  output lssd_pkg::err_t           out_track_error,
  output lssd_pkg::sample_t        out_average,
  output logic [1:0]               out_drive_command,
  output logic                     out_sum_zero_fault
);

  // configuration
  lssd_pkg::dist_t   obstacle_limit_r;
  lssd_pkg::sample_t dark_threshold_r;
  lssd_pkg::sample_t bright_threshold_r;
  lssd_pkg::band_t   dead_band_r;
  lssd_pkg::band_t   turn_limit_r;

  // architectural state
  lssd_pkg::cent_t      set_point_r;
  lssd_pkg::drive_cmd_t last_cmd_r;

  // working registers
  lssd_pkg::sample_t   samp_r [lssd_pkg::NUM_SENSORS];
  logic                op_r;
  lssd_pkg::dist_t     dist_r;
  lssd_pkg::sum_t      sum_r;
  lssd_pkg::wsum_t     wsum_r;
  lssd_pkg::div_word_t rem_r;
  lssd_pkg::div_word_t dsh_r;
  lssd_pkg::cent_t     quo_r;

  // result register
  lssd_pkg::cent_t      cent_out_r;
  lssd_pkg::err_t       err_out_r;
  lssd_pkg::sample_t    avg_out_r;
  lssd_pkg::drive_cmd_t cmd_out_r;
  logic                 fault_out_r;

  lssd_pkg::sum_t       sum_nxt;
  lssd_pkg::div_word_t  wsum_ext;
  logic                 quo_bit;
  lssd_pkg::sample_t    avg;
  lssd_pkg::err_wide_t  err_w;
  lssd_pkg::err_wide_t  db_w;
  lssd_pkg::err_wide_t  tl_w;
  lssd_pkg::drive_cmd_t decision;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obstacle_limit_r   <= lssd_pkg::dist_t'(30);
      dark_threshold_r   <= lssd_pkg::sample_t'(500);
      bright_threshold_r <= lssd_pkg::sample_t'(2000);
      dead_band_r        <= lssd_pkg::band_t'(8);
      turn_limit_r       <= lssd_pkg::band_t'(25);
    end else if (cfg_we) begin
      case (cfg_index)
        lssd_pkg::CFG_OBSTACLE_LIMIT:   obstacle_limit_r   <= cfg_data;
        lssd_pkg::CFG_DARK_THRESHOLD:
          dark_threshold_r <= cfg_data[lssd_pkg::SAMPLE_BITS-1:0];
        lssd_pkg::CFG_BRIGHT_THRESHOLD:
          bright_threshold_r <= cfg_data[lssd_pkg::SAMPLE_BITS-1:0];
        lssd_pkg::CFG_DEAD_BAND:        dead_band_r  <= cfg_data[lssd_pkg::BAND_W-1:0];
        lssd_pkg::CFG_TURN_LIMIT:       turn_limit_r <= cfg_data[lssd_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // samples go through highest index first; adding the running sum into
  // wsum each step weights sample i by (i + 1)
  assign sum_nxt  = sum_r + lssd_pkg::sum_t'(samp_r[lssd_pkg::NUM_SENSORS-1]);
  assign wsum_ext = lssd_pkg::div_word_t'(wsum_r);
  assign quo_bit  = (rem_r >= dsh_r);
  assign sum_zero = (sum_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      samp_r <= in_samples;
      op_r   <= in_operation;
      dist_r <= in_distance_cm;
      sum_r  <= '0;
      wsum_r <= '0;
    end else if (cmd.acc) begin
      for (int i = lssd_pkg::NUM_SENSORS - 1; i > 0; i--) begin
        samp_r[i] <= samp_r[i-1];
      end
      sum_r  <= sum_nxt;
      wsum_r <= wsum_r + lssd_pkg::wsum_t'(sum_nxt);
    end
    if (cmd.scale) begin
      rem_r <= (wsum_ext << 3) + (wsum_ext << 1);
      dsh_r <= lssd_pkg::div_word_t'(sum_r) << (lssd_pkg::CENT_W - 1);
      quo_r <= '0;
    end else if (cmd.div_step) begin
      if (quo_bit) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      quo_r <= {quo_r[lssd_pkg::CENT_W-2:0], quo_bit};
    end
  end

  // decision
  assign avg   = lssd_pkg::sample_t'(sum_r / lssd_pkg::NUM_SENSORS);
  assign err_w = lssd_pkg::err_wide_t'({2'b00, quo_r})
               - lssd_pkg::err_wide_t'({2'b00, set_point_r});
  assign db_w  = lssd_pkg::err_wide_t'({2'b00, dead_band_r});
  assign tl_w  = lssd_pkg::err_wide_t'({2'b00, turn_limit_r});

  always_comb begin
    decision = last_cmd_r;
    if (dist_r <= obstacle_limit_r) begin
      decision = lssd_pkg::CMD_STOP;
    end else if (avg < dark_threshold_r) begin
      decision = lssd_pkg::CMD_FORWARD;
    end else if (avg > bright_threshold_r) begin
      decision = lssd_pkg::CMD_STOP;
    end else begin
      // later band wins where bands overlap
      if (err_w < db_w && err_w > -db_w) begin
        decision = lssd_pkg::CMD_FORWARD;
      end
      if (err_w <= -db_w && err_w >= -tl_w) begin
        decision = lssd_pkg::CMD_LEFT;
      end
      if (err_w >= db_w && err_w <= tl_w) begin
        decision = lssd_pkg::CMD_RIGHT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_point_r <= '0;
      last_cmd_r  <= lssd_pkg::CMD_STOP;
    end else if (cmd.out_load && !sum_zero) begin
      if (op_r == 1'(lssd_pkg::OP_CALIBRATE)) begin
        set_point_r <= quo_r;
      end else begin
        last_cmd_r <= decision;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (sum_zero) begin
        cent_out_r  <= '0;
        err_out_r   <= '0;
        avg_out_r   <= '0;
        cmd_out_r   <= last_cmd_r;
        fault_out_r <= 1'b1;
      end else begin
        cent_out_r  <= quo_r;
        err_out_r   <= err_w[lssd_pkg::ERR_W-1:0];
        avg_out_r   <= avg;
        cmd_out_r   <= (op_r == 1'(lssd_pkg::OP_RUN)) ? decision : last_cmd_r;
        fault_out_r <= 1'b0;
      end
    end
  end

  assign out_centroid       = cent_out_r;
  assign out_track_error    = err_out_r;
  assign out_average        = avg_out_r;
  assign out_drive_command  = cmd_out_r;
  assign out_sum_zero_fault = fault_out_r;

endmodule

[rtl/line_sensor_steering_decider.sv]
// Top level of the line sensor steering decider.
// Each item is one frame of eight reflectance samples, a range reading and an
// operation (0 calibrate, 1 run); it yields one result: weighted centroid
// (ten times the mean sensor position, 1-based), error against the stored set
// point, sample average, drive command and an all-zero fault flag. An item
// passes from acceptance to result one sample per cycle through the
// accumulator, a scale cycle, one quotient bit per cycle through the
// restoring divider and a decision cycle that loads the output register;
// the next item can be taken in the cycle after the result is registered.
// An all-zero frame skips the divider. The decision cycle stretches while
// the output register still holds a result the receiver has not taken. The
// result waits in an output register while the next frame is taken.
// Configuration writes are always accepted and must be issued only while no
// frame is in flight.
module line_sensor_steering_decider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [11:0] in_sample_0,
  input  logic [11:0] in_sample_1,
  input  logic [11:0] in_sample_2,
  input  logic [11:0] in_sample_3,
  input  logic [11:0] in_sample_4,
  input  logic [11:0] in_sample_5,
  input  logic [11:0] in_sample_6,
  input  logic [11:0] in_sample_7,
  input  logic [15:0] in_distance_cm,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_centroid,
  output logic signed [7:0] out_track_error,
  output logic [11:0] out_average,
  output logic [1:0]  out_drive_command,
  output logic        out_sum_zero_fault,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  lssd_pkg::lssd_cmd_t cmd;
  logic                sum_zero;
  lssd_pkg::sample_t   samples [lssd_pkg::NUM_SENSORS];

  assign samples[0] = in_sample_0;
  assign samples[1] = in_sample_1;
  assign samples[2] = in_sample_2;
  assign samples[3] = in_sample_3;
  assign samples[4] = in_sample_4;
  assign samples[5] = in_sample_5;
  assign samples[6] = in_sample_6;
  assign samples[7] = in_sample_7;

  assign cfg_ready = 1'b1;

  lssd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sum_zero  (sum_zero),
    .cmd       (cmd)
  );

  lssd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sum_zero           (sum_zero),
    .in_operation       (in_operation),
    .in_samples         (samples),
    .in_distance_cm     (in_distance_cm),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_centroid       (out_centroid),
    .out_track_error    (out_track_error),
    .out_average        (out_average),
    .out_drive_command  (out_drive_command),
    .out_sum_zero_fault (out_sum_zero_fault)
  );

  // one frame in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("frame accepted while another is in flight");

  // faulted result carries zeroed centroid, error and average
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sum_zero_fault) |->
      (out_centroid == 7'd0 && out_track_error == 8'sd0 && out_average == 12'd0))
    else $error("fault result with nonzero fields");

  // centroid lies between the lowest and highest weight, times ten
  a_centroid_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_sum_zero_fault) |->
      (out_centroid >= 7'd10 && out_centroid <= 7'd80))
    else $error("centroid out of range");

endmodule
